/* src/tlvd_pkg.sv */
// ----------------------------------------------------------------------------
// TLV stream deframer package
// Shared constants and the state and result types of the deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  // Header layout: a 4-byte length followed by a 4-byte type, little-endian.
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LEN_BYTES    = 4;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

  localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS = HDR_CNT_W'(HEADER_BYTES - 1);

  // Parsing state carried from one byte to the next.
  typedef struct packed {
    logic                 in_payload;
    logic [HDR_CNT_W-1:0] header_count;
    logic [31:0]          length_value;
    logic [31:0]          type_value;
    logic [31:0]          bytes_remaining;
    logic                 payload_started;
  } tlvd_state_t;

  // One result item, with a flag telling whether the byte produced one.
  typedef struct packed {
    logic        valid;
    logic        is_empty_message;
    logic [31:0] message_type;
    logic [7:0]  payload_byte;
    logic        first_of_message;
    logic        last_of_message;
  } tlvd_result_t;

  localparam tlvd_state_t STATE_RESET = '{
    in_payload:      1'b0,
    header_count:    '0,
    length_value:    32'd0,
    type_value:      32'd0,
    bytes_remaining: 32'd0,
    payload_started: 1'b0
  };

endpackage

/* src/tlvd_parser.sv */
// ----------------------------------------------------------------------------
// TLV stream deframer byte parser
// Works out the next parsing state and the result for one received byte.
// ----------------------------------------------------------------------------
module tlvd_parser (
  input  tlvd_pkg::tlvd_state_t  state,
  input  logic [7:0]             data_byte,
  output tlvd_pkg::tlvd_state_t  state_nxt,
  output tlvd_pkg::tlvd_result_t result
);

  logic [tlvd_pkg::HDR_CNT_W-1:0] pos;
  logic [31:0]                    len_base;
  logic [31:0]                    typ_base;
  logic                           last_byte;

  assign pos = state.header_count;

  // Header assembly: clear on the first header byte, then place each byte
  // at its little-endian position in the length or the type.
  always_comb begin
    len_base = (pos == '0) ? 32'd0 : state.length_value;
    typ_base = (pos == '0) ? 32'd0 : state.type_value;
    if (32'(pos) < tlvd_pkg::LEN_BYTES) begin
      len_base[{pos[1:0], 3'b000} +: 8] = len_base[{pos[1:0], 3'b000} +: 8] | data_byte;
    end else begin
      typ_base[{pos[1:0], 3'b000} +: 8] = typ_base[{pos[1:0], 3'b000} +: 8] | data_byte;
    end
  end

  // A payload byte is the last one when at most one remains.
  assign last_byte = (state.bytes_remaining <= 32'd1);

  // Next state and result selection.
  always_comb begin
    state_nxt = state;
    result    = '0;
    if (!state.in_payload) begin
      state_nxt.length_value = len_base;
      state_nxt.type_value   = typ_base;
      if (pos != tlvd_pkg::HDR_LAST_POS) begin
        state_nxt.header_count = pos + 1'b1;
      end else begin
        state_nxt.header_count = '0;
        if (len_base == 32'd0) begin
          // Zero-length message: a single empty-message result.
          result.valid            = 1'b1;
          result.is_empty_message = 1'b1;
          result.message_type     = typ_base;
          result.first_of_message = 1'b1;
          result.last_of_message  = 1'b1;
        end else begin
          state_nxt.in_payload      = 1'b1;
          state_nxt.bytes_remaining = len_base;
          state_nxt.payload_started = 1'b0;
        end
      end
    end else begin
      result.valid            = 1'b1;
      result.message_type     = state.type_value;
      result.payload_byte     = data_byte;
      result.first_of_message = !state.payload_started;
      result.last_of_message  = last_byte;
      state_nxt.payload_started = 1'b1;
      if (last_byte) begin
        state_nxt.bytes_remaining = 32'd0;
        state_nxt.in_payload      = 1'b0;
        state_nxt.payload_started = 1'b0;
        state_nxt.header_count    = '0;
      end else begin
        state_nxt.bytes_remaining = state.bytes_remaining - 32'd1;
      end
    end
  end

endmodule

/* src/tlv_stream_deframer.sv */
// ----------------------------------------------------------------------------
// TLV stream deframer
// Splits a byte stream of length/type/payload messages into payload bytes
// tagged with the message type and first/last markers.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_ready  | in_data_byte
//   out_    | output    | out_valid/out_ready| out_is_empty_message,
//           |           |                    | out_message_type, out_payload_byte,
//           |           |                    | out_first_of_message,
//           |           |                    | out_last_of_message
//
// One byte is accepted per clock cycle while the output register is free or
// being emptied; its result, if any, appears in the output register on the next
// cycle. The parse from the state registers into the output register is combinational.
// Synchronous active-low reset returns the parser to expecting a header.
// While the output register holds a result that is not taken, input transfers
// stop; they resume in the cycle the result is transferred.
// ----------------------------------------------------------------------------
module tlv_stream_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_empty_message,
  output logic [31:0] out_message_type,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_message,
  output logic        out_last_of_message
);

  tlvd_pkg::tlvd_state_t  state_r;
  tlvd_pkg::tlvd_state_t  state_nxt;
  tlvd_pkg::tlvd_result_t result;
  logic                   out_valid_r;
  logic                   out_empty_r;
  logic [31:0]            out_type_r;
  logic [7:0]             out_byte_r;
  logic                   out_first_r;
  logic                   out_last_r;
  logic                   in_xfer;

  // Accept whenever the output register is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Per-byte parse.
  tlvd_parser u_parser (
    .state     (state_r),
    .data_byte (in_data_byte),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Parsing state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlvd_pkg::STATE_RESET;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= result.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register, loaded when a transfer yields a result.
  always_ff @(posedge clk) begin
    if (in_xfer && result.valid) begin
      out_empty_r <= result.is_empty_message;
      out_type_r  <= result.message_type;
      out_byte_r  <= result.payload_byte;
      out_first_r <= result.first_of_message;
      out_last_r  <= result.last_of_message;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_is_empty_message = out_empty_r;
  assign out_message_type     = out_type_r;
  assign out_payload_byte     = out_byte_r;
  assign out_first_of_message = out_first_r;
  assign out_last_of_message  = out_last_r;

endmodule

/* test/tlv_stream_deframer_test.sv */
// ----------------------------------------------------------------------------
// TLV stream deframer testbench
// Drives byte streams of length/type/payload messages into the deframer. A
// scoreboard predicts each tagged payload byte or empty-message result, and
// every output transfer is compared with the oldest prediction. Sender and
// receiver stall at random in several phases, and the run ends with a message
// whose length is close to the 32-bit limit.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_BYTES = 660;

  // One output transfer of the deframer.
  typedef struct packed {
    logic        is_empty_message;
    logic [31:0] message_type;
    logic [7:0]  payload_byte;
    logic        first_of_message;
    logic        last_of_message;
  } deframed_t;

  // Scoreboard: tracks the header/payload parse and holds the predicted
  // outputs until they are transferred.
  class deframe_scoreboard;
    bit                 in_payload;
    logic [2:0]         header_pos;
    logic [31:0]        msg_length;
    logic [31:0]        msg_type;
    logic [31:0]        remaining;
    bit                 started;
    deframed_t          expected_outputs[$];
    int unsigned        mismatches;

    function new();
      in_payload = 1'b0;
      header_pos = '0;
      msg_length = '0;
      msg_type   = '0;
      remaining  = '0;
      started    = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_outputs.size();
    endfunction

    // Advances the parse by one accepted byte and queues its output, if any.
    function void note_byte(input logic [7:0] b);
      deframed_t exp_out;
      if (!in_payload) begin
        if (header_pos == 0) begin
          msg_length = '0;
          msg_type   = '0;
        end
        if (header_pos < tlvd_pkg::LEN_BYTES) begin
          msg_length[8*header_pos +: 8] = b;
        end else begin
          msg_type[8*(header_pos - tlvd_pkg::LEN_BYTES) +: 8] = b;
        end
        if (header_pos != tlvd_pkg::HEADER_BYTES - 1) begin
          header_pos = header_pos + 1'b1;
        end else begin
          header_pos = '0;
          if (msg_length == 0) begin
            // A zero-length message ends at its last header byte.
            exp_out = '{1'b1, msg_type, 8'h00, 1'b1, 1'b1};
            expected_outputs = {expected_outputs, exp_out};
          end else begin
            in_payload = 1'b1;
            remaining  = msg_length;
            started    = 1'b0;
          end
        end
      end else begin
        exp_out = '{1'b0, msg_type, b, !started, remaining <= 1};
        expected_outputs = {expected_outputs, exp_out};
        started = 1'b1;
        if (remaining <= 1) begin
          remaining  = '0;
          in_payload = 1'b0;
          started    = 1'b0;
          header_pos = '0;
        end else begin
          remaining = remaining - 1;
        end
      end
    endfunction

    // Compares one output transfer with the oldest prediction.
    function void check_output(input deframed_t got);
      deframed_t exp_out;
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected output transfer, actual %h", $realtime, got);
        mismatches++;
        return;
      end
      exp_out = expected_outputs.pop_front();
      if (got.is_empty_message !== exp_out.is_empty_message) begin
        $display("%0t: is_empty_message expected %0b actual %0b", $realtime,
                 exp_out.is_empty_message, got.is_empty_message);
        mismatches++;
      end
      if (got.message_type !== exp_out.message_type) begin
        $display("%0t: message_type expected %h actual %h", $realtime,
                 exp_out.message_type, got.message_type);
        mismatches++;
      end
      if (got.payload_byte !== exp_out.payload_byte) begin
        $display("%0t: payload_byte expected %h actual %h", $realtime,
                 exp_out.payload_byte, got.payload_byte);
        mismatches++;
      end
      if (got.first_of_message !== exp_out.first_of_message) begin
        $display("%0t: first_of_message expected %0b actual %0b", $realtime,
                 exp_out.first_of_message, got.first_of_message);
        mismatches++;
      end
      if (got.last_of_message !== exp_out.last_of_message) begin
        $display("%0t: last_of_message expected %0b actual %0b", $realtime,
                 exp_out.last_of_message, got.last_of_message);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_empty_message;
  logic [31:0] out_message_type;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_message;
  logic        out_last_of_message;

  deframe_scoreboard sb;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       stall_cycles = 0;

  tlv_stream_deframer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_empty_message (out_is_empty_message),
    .out_message_type     (out_message_type),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output('{out_is_empty_message, out_message_type, out_payload_byte,
                        out_first_of_message, out_last_of_message});
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tlv_stream_deframer_test: errors");
        $finish;
      end
    end
  end

  // Sends one byte, with random idle cycles in front of it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sends a header and then len payload bytes (random unless fill is given).
  task automatic send_message(input logic [31:0] len, input logic [31:0] typ,
                              input int fill);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(typ[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(fill < 0 ? 8'($urandom_range(255)) : fill[7:0]);
    end
  endtask

  // Holds the sender off until every predicted output has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random messages: mostly short, some empty, a few long enough to carry
  // into the second length byte.
  task automatic run_phase(input int unsigned n_bytes);
    int unsigned   start;
    int unsigned   pick;
    logic [31:0]   len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        len = 0;
      end else if (pick < 92) begin
        len = $urandom_range(1, 12);
      end else begin
        len = $urandom_range(13, 300);
      end
      send_message(len, $urandom, -1);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, single-byte message, extreme bytes and types.
    send_message(32'd0, 32'h0000_0000, -1);
    send_message(32'd1, 32'hFFFF_FFFF, 8'hFF);
    send_byte(8'd4);
    for (int i = 0; i < 3; i++) send_byte(8'h00);
    send_message(32'd0, 32'h8000_0001, -1);
    for (int i = 0; i < 8; i++) send_byte(8'h00);
    wait_drained();

    // Receiver idles more than sender, then the reverse, then neither.
    send_idle_pct = 30;
    recv_idle_pct = 72;
    run_phase(PHASE_BYTES);
    send_idle_pct = 72;
    recv_idle_pct = 30;
    run_phase(PHASE_BYTES);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_BYTES);

    // A huge length is taken as it is; only its opening bytes are sent.
    send_byte(8'hFE);
    for (int i = 0; i < 3; i++) send_byte(8'hFF);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)));
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tlv_stream_deframer_test: clean");
    end else begin
      $display("tlv_stream_deframer_test: errors");
    end
    $finish;
  end

endmodule
